// ----- rtl/core/source_token_scanner_macros.svh -----
// Assertion macros shared by the token scanner RTL.
`ifndef SOURCE_TOKEN_SCANNER_MACROS_SVH
`define SOURCE_TOKEN_SCANNER_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds at every clock edge outside reset.
`define STS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("token scanner check failed");
// Check that a condition never holds outside reset.
`define STS_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("token scanner forbidden condition seen");
`else
`define STS_ASSERT(label, clk, rst, prop)
`define STS_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

// ----- rtl/core/sts_pkg.sv -----
// Types, codes and per-byte scanning functions of the token scanner.
package sts_pkg;

   localparam int POS_BITS   = 24;
   localparam int LINE_BITS  = 24;
   localparam int NEST_LIMIT = 15;
   localparam int KW_COUNT   = 16;

   typedef logic [POS_BITS-1:0]  pos_type;
   typedef logic [LINE_BITS-1:0] line_type;
   typedef logic [5:0]           kind_type;
   typedef logic [2:0]           err_type;

   localparam pos_type  POS_MAX  = '1;
   localparam line_type LINE_MAX = '1;

   typedef enum logic [3:0] {
      MODE_IDLE, MODE_IDENT, MODE_ZERO, MODE_NUMBER, MODE_STRING,
      MODE_SLASH, MODE_LINECOM, MODE_BLOCKCOM, MODE_OP1, MODE_OP2
   } mode_type;

   localparam kind_type K_EOF     = 6'd0;
   localparam kind_type K_IDENT   = 6'd1;
   localparam kind_type K_KW0     = 6'd2;
   localparam kind_type K_AND     = 6'd2;
   localparam kind_type K_OR      = 6'd12;
   localparam kind_type K_INT     = 6'd18;
   localparam kind_type K_OCT     = 6'd19;
   localparam kind_type K_BIN     = 6'd20;
   localparam kind_type K_HEX     = 6'd21;
   localparam kind_type K_FLOAT   = 6'd22;
   localparam kind_type K_DOUBLE  = 6'd23;
   localparam kind_type K_STRING  = 6'd24;
   localparam kind_type K_LPAREN  = 6'd25;
   localparam kind_type K_RPAREN  = 6'd26;
   localparam kind_type K_LBRACE  = 6'd27;
   localparam kind_type K_RBRACE  = 6'd28;
   localparam kind_type K_LBRACK  = 6'd29;
   localparam kind_type K_RBRACK  = 6'd30;
   localparam kind_type K_SEMI    = 6'd31;
   localparam kind_type K_COMMA   = 6'd32;
   localparam kind_type K_DOT     = 6'd33;
   localparam kind_type K_MINUS   = 6'd34;
   localparam kind_type K_PLUS    = 6'd35;
   localparam kind_type K_SLASH   = 6'd36;
   localparam kind_type K_STAR    = 6'd37;
   localparam kind_type K_AMP     = 6'd38;
   localparam kind_type K_AMPEQ   = 6'd39;
   localparam kind_type K_PIPE    = 6'd40;
   localparam kind_type K_PIPEEQ  = 6'd41;
   localparam kind_type K_BANG    = 6'd42;
   localparam kind_type K_BANGEQ  = 6'd43;
   localparam kind_type K_ASSIGN  = 6'd44;
   localparam kind_type K_EQEQ    = 6'd45;
   localparam kind_type K_LT      = 6'd46;
   localparam kind_type K_LE      = 6'd47;
   localparam kind_type K_SHL     = 6'd48;
   localparam kind_type K_GT      = 6'd50;
   localparam kind_type K_GE      = 6'd51;
   localparam kind_type K_SHR     = 6'd52;
   localparam kind_type K_NEWLINE = 6'd54;
   localparam kind_type K_ERROR   = 6'd55;

   localparam err_type E_NONE       = 3'd0;
   localparam err_type E_BIN_FLOAT  = 3'd1;
   localparam err_type E_HEX_FLOAT  = 3'd2;
   localparam err_type E_BAD_OCT    = 3'd3;
   localparam err_type E_BAD_BIN    = 3'd4;
   localparam err_type E_OPEN_STR   = 3'd5;
   localparam err_type E_UNEXPECTED = 3'd6;

   localparam logic [2:0] R_OCT = 3'b001;
   localparam logic [2:0] R_BIN = 3'b010;
   localparam logic [2:0] R_HEX = 3'b100;

   typedef struct packed {
      mode_type              mode;
      kind_type              pending_kind;
      pos_type               tok_start;
      pos_type               tok_len;
      line_type              line;
      pos_type               pos;
      logic [2:0]            radix;
      logic [1:0]            phase;
      logic                  fault;
      logic [KW_COUNT-1:0]   cand;
      logic [3:0]            depth;
      logic [7:0]            held;
   } scan_state_type;

   typedef struct packed {
      kind_type    kind;
      err_type     err;
      logic [23:0] start;
      logic [23:0] len;
      logic [23:0] line;
      logic        last;
   } token_type;

   typedef struct packed {
      scan_state_type st;
      logic           emit;
      token_type      tok;
      logic           consumed;
   } step_type;

   // Tokens produced by one accepted byte, packed from slot 0.
   typedef struct packed {
      logic [1:0]      count;
      token_type [2:0] tok;
   } push_type;

   function automatic scan_state_type reset_state();
      scan_state_type s;
      s      = '0;
      s.mode = MODE_IDLE;
      s.line = line_type'(1);
      return s;
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_dec(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_hexd(logic [7:0] c);
      return is_dec(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic pos_type sat_pos(pos_type v);
      return (v == POS_MAX) ? v : v + 1'b1;
   endfunction

   function automatic line_type sat_line(line_type v);
      return (v == LINE_MAX) ? v : v + 1'b1;
   endfunction

   function automatic logic [3:0] kw_len(logic [3:0] k);
      logic [3:0] n;
      unique case (k)
         4'd0:  n = 4'd3;
         4'd1:  n = 4'd5;
         4'd2:  n = 4'd4;
         4'd3:  n = 4'd5;
         4'd4:  n = 4'd4;
         4'd5:  n = 4'd5;
         4'd6:  n = 4'd3;
         4'd7:  n = 4'd2;
         4'd8:  n = 4'd9;
         4'd9:  n = 4'd3;
         4'd10: n = 4'd2;
         4'd11: n = 4'd6;
         4'd12: n = 4'd6;
         4'd13: n = 4'd4;
         4'd14: n = 4'd5;
         default: n = 4'd5;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] kw_char(logic [3:0] k, logic [3:0] idx);
      logic [71:0] w;
      logic [3:0]  n;
      logic [7:0]  c;
      unique case (k)
         4'd0:  w = "and";
         4'd1:  w = "break";
         4'd2:  w = "case";
         4'd3:  w = "class";
         4'd4:  w = "else";
         4'd5:  w = "false";
         4'd6:  w = "for";
         4'd7:  w = "if";
         4'd8:  w = "implement";
         4'd9:  w = "not";
         4'd10: w = "or";
         4'd11: w = "return";
         4'd12: w = "switch";
         4'd13: w = "type";
         4'd14: w = "using";
         default: w = "while";
      endcase
      n = kw_len(k);
      c = 8'h00;
      // Text sits right-aligned, so character idx lies (n-1-idx) bytes up.
      if (idx < n) begin
         c = w[(n - 4'd1 - idx)*8 +: 8];
      end
      return c;
   endfunction

   function automatic logic [KW_COUNT-1:0] filter_kw(logic [KW_COUNT-1:0] cand,
                                                    logic [7:0] c, pos_type idx);
      logic [KW_COUNT-1:0] keep;
      for (int k = 0; k < KW_COUNT; k++) begin
         keep[k] = cand[k] && (idx < pos_type'(kw_len(4'(k))))
                   && (kw_char(4'(k), idx[3:0]) == c);
      end
      return keep;
   endfunction

   function automatic kind_type ident_kind(scan_state_type s);
      kind_type kind;
      kind = K_IDENT;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (s.cand[k] && s.tok_len == pos_type'(kw_len(4'(k)))) begin
            kind = K_KW0 + 6'(k);
         end
      end
      return kind;
   endfunction

   // Emit the pending token from the current state and return to idle.
   function automatic step_type close_tok(step_type r, kind_type kind, err_type err);
      step_type o;
      o            = r;
      o.emit       = 1'b1;
      o.tok.kind   = kind;
      o.tok.err    = err;
      o.tok.start  = 24'(r.st.tok_start);
      o.tok.len    = 24'(r.st.tok_len);
      o.tok.line   = 24'(r.st.line);
      o.tok.last   = 1'b0;
      o.st.mode    = MODE_IDLE;
      return o;
   endfunction

   function automatic step_type number_step(scan_state_type s, logic [7:0] b);
      step_type r;
      logic     hex;
      logic     bin;
      logic     oct;
      r          = '0;
      r.st       = s;
      r.consumed = 1'b1;
      hex        = (s.radix & R_HEX) != 3'b000;
      bin        = (s.radix & R_BIN) != 3'b000;
      oct        = (s.radix & R_OCT) != 3'b000;
      if (s.phase == 2'd0) begin
         if (hex ? is_hexd(b) : is_dec(b)) begin
            if ((oct && b >= "8") || (bin && b >= "2")) begin
               r.st.fault = 1'b1;
            end
            r.st.tok_len = sat_pos(s.tok_len);
         end else if (b == ".") begin
            r.st.tok_len = sat_pos(s.tok_len);
            if (bin) begin
               r = close_tok(r, K_ERROR, E_BIN_FLOAT);
            end else if (hex) begin
               r = close_tok(r, K_ERROR, E_HEX_FLOAT);
            end else begin
               r.st.phase = 2'd1;
            end
         end else if (b == "f") begin
            r.st.tok_len = sat_pos(s.tok_len);
            r = bin ? close_tok(r, K_ERROR, E_BIN_FLOAT) : close_tok(r, K_FLOAT, E_NONE);
         end else begin
            r.consumed = 1'b0;
            if (oct) begin
               r = s.fault ? close_tok(r, K_ERROR, E_BAD_OCT) : close_tok(r, K_OCT, E_NONE);
            end else if (bin) begin
               r = s.fault ? close_tok(r, K_ERROR, E_BAD_BIN) : close_tok(r, K_BIN, E_NONE);
            end else if (hex) begin
               r = close_tok(r, K_HEX, E_NONE);
            end else begin
               r = close_tok(r, K_INT, E_NONE);
            end
         end
      end else begin
         if (is_dec(b)) begin
            r.st.tok_len = sat_pos(s.tok_len);
         end else if (b == "f") begin
            r.st.tok_len = sat_pos(s.tok_len);
            r = close_tok(r, K_FLOAT, E_NONE);
         end else begin
            r.consumed = 1'b0;
            r = close_tok(r, K_DOUBLE, E_NONE);
         end
      end
      return r;
   endfunction

   function automatic step_type op1_step(scan_state_type s, logic [7:0] b);
      step_type r;
      kind_type single;
      kind_type k2;
      kind_type k3;
      logic [7:0] c2;
      logic [7:0] c3;
      r          = '0;
      r.st       = s;
      r.consumed = 1'b1;
      k3         = K_EOF;
      c3         = 8'h00;
      unique case (s.held)
         "&": begin
            single = K_AMP;    c2 = "&"; k2 = K_AND;  c3 = "="; k3 = K_AMPEQ;
         end
         "|": begin
            single = K_PIPE;   c2 = "|"; k2 = K_OR;   c3 = "="; k3 = K_PIPEEQ;
         end
         "!": begin
            single = K_BANG;   c2 = "="; k2 = K_BANGEQ;
         end
         "=": begin
            single = K_ASSIGN; c2 = "="; k2 = K_EQEQ;
         end
         "<": begin
            single = K_LT;     c2 = "="; k2 = K_LE;   c3 = "<"; k3 = K_SHL;
         end
         default: begin
            single = K_GT;     c2 = "="; k2 = K_GE;   c3 = ">"; k3 = K_SHR;
         end
      endcase
      if (b == c2) begin
         r.st.tok_len = sat_pos(s.tok_len);
         r = close_tok(r, k2, E_NONE);
      end else if (c3 != 8'h00 && b == c3) begin
         r.st.tok_len = sat_pos(s.tok_len);
         if (k3 == K_SHL || k3 == K_SHR) begin
            r.st.pending_kind = k3;
            r.st.mode         = MODE_OP2;
         end else begin
            r = close_tok(r, k3, E_NONE);
         end
      end else begin
         r.consumed = 1'b0;
         r = close_tok(r, single, E_NONE);
      end
      return r;
   endfunction

   // Feed a byte to the pending token; consumed is low if it was not taken.
   function automatic step_type cont_step(scan_state_type s, logic [7:0] b);
      step_type       r;
      scan_state_type z;
      r          = '0;
      r.st       = s;
      r.consumed = 1'b1;
      z          = s;
      unique case (s.mode)
         MODE_IDENT: begin
            if (is_alpha(b) || b == "_" || is_dec(b)) begin
               r.st.cand    = filter_kw(s.cand, b, s.tok_len);
               r.st.tok_len = sat_pos(s.tok_len);
            end else begin
               r.consumed = 1'b0;
               r = close_tok(r, ident_kind(s), E_NONE);
            end
         end
         MODE_ZERO: begin
            z.mode  = MODE_NUMBER;
            z.phase = 2'd0;
            z.fault = 1'b0;
            if (b == "b" || b == "x") begin
               z.radix   = (b == "b") ? R_BIN : R_HEX;
               z.tok_len = sat_pos(s.tok_len);
               r.st      = z;
            end else begin
               z.radix = R_OCT;
               r = number_step(z, b);
            end
         end
         MODE_NUMBER: r = number_step(s, b);
         MODE_STRING: begin
            r.st.tok_len = sat_pos(s.tok_len);
            if (b == "\"") begin
               r = close_tok(r, K_STRING, E_NONE);
            end else if (b == "\n") begin
               r.st.line = sat_line(s.line);
            end
         end
         MODE_SLASH: begin
            if (b == "/") begin
               r.st.mode = MODE_LINECOM;
            end else if (b == "*") begin
               r.st.mode  = MODE_BLOCKCOM;
               r.st.depth = 4'd1;
               r.st.held  = 8'h00;
            end else begin
               r.consumed = 1'b0;
               r = close_tok(r, K_SLASH, E_NONE);
            end
         end
         MODE_LINECOM: begin
            if (b == "\n") begin
               r.st.mode  = MODE_IDLE;
               r.consumed = 1'b0;
            end
         end
         MODE_BLOCKCOM: begin
            if (b == "\n") begin
               r.st.line = sat_line(s.line);
            end
            if (s.held == "*" && b == "/") begin
               r.st.held = 8'h00;
               if (s.depth != 4'd0) begin
                  r.st.depth = s.depth - 4'd1;
               end
               if (s.depth <= 4'd1) begin
                  r.st.mode = MODE_IDLE;
               end
            end else if (s.held == "/" && b == "*") begin
               r.st.held = 8'h00;
               if (s.depth < 4'(NEST_LIMIT)) begin
                  r.st.depth = s.depth + 4'd1;
               end
            end else begin
               r.st.held = (b == "*" || b == "/") ? b : 8'h00;
            end
         end
         MODE_OP1: r = op1_step(s, b);
         MODE_OP2: begin
            if (b == "=") begin
               r.st.tok_len = sat_pos(s.tok_len);
               r = close_tok(r, s.pending_kind + 6'd1, E_NONE);
            end else begin
               r.consumed = 1'b0;
               r = close_tok(r, s.pending_kind, E_NONE);
            end
         end
         default: begin
            r.st.mode  = MODE_IDLE;
            r.consumed = 1'b0;
         end
      endcase
      return r;
   endfunction

   // Open a token on a byte seen between tokens.
   function automatic step_type start_step(scan_state_type s, logic [7:0] b);
      step_type r;
      r              = '0;
      r.st           = s;
      r.consumed     = 1'b1;
      r.st.tok_start = s.pos;
      r.st.tok_len   = pos_type'(1);
      priority if (b == " " || b == "\t" || b == "\r") begin
         r.st.mode = s.mode;
      end else if (is_alpha(b) || b == "_") begin
         r.st.mode = MODE_IDENT;
         r.st.cand = filter_kw('1, b, '0);
      end else if (b == "0") begin
         r.st.mode = MODE_ZERO;
      end else if (is_dec(b)) begin
         r.st.mode  = MODE_NUMBER;
         r.st.radix = 3'b000;
         r.st.phase = 2'd0;
         r.st.fault = 1'b0;
      end else begin
         unique case (b)
            "(": r = close_tok(r, K_LPAREN, E_NONE);
            ")": r = close_tok(r, K_RPAREN, E_NONE);
            "{": r = close_tok(r, K_LBRACE, E_NONE);
            "}": r = close_tok(r, K_RBRACE, E_NONE);
            "[": r = close_tok(r, K_LBRACK, E_NONE);
            "]": r = close_tok(r, K_RBRACK, E_NONE);
            ";": r = close_tok(r, K_SEMI, E_NONE);
            ",": r = close_tok(r, K_COMMA, E_NONE);
            ".": r = close_tok(r, K_DOT, E_NONE);
            "-": r = close_tok(r, K_MINUS, E_NONE);
            "+": r = close_tok(r, K_PLUS, E_NONE);
            "*": r = close_tok(r, K_STAR, E_NONE);
            "/": r.st.mode = MODE_SLASH;
            "&", "|", "!", "=", "<", ">": begin
               r.st.mode = MODE_OP1;
               r.st.held = b;
            end
            "\"": r.st.mode = MODE_STRING;
            "\n": begin
               r = close_tok(r, K_NEWLINE, E_NONE);
               r.st.line = sat_line(s.line);
            end
            default: r = close_tok(r, K_ERROR, E_UNEXPECTED);
         endcase
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/sts_req_if.sv -----
// Source byte channel of the token scanner.
interface sts_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_input;

   modport source (output valid, output in_byte, output end_of_input, input ready);
   modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

// ----- rtl/core/sts_rsp_if.sv -----
// Token channel of the token scanner.
interface sts_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  token_kind;
   logic [2:0]  error_code;
   logic [23:0] start_offset;
   logic [23:0] token_length;
   logic [23:0] line_number;
   logic        last;

   modport source (output valid, output token_kind, output error_code, output start_offset,
                   output token_length, output line_number, output last, input ready);
   modport sink (input valid, input token_kind, input error_code, input start_offset,
                 input token_length, input line_number, input last, output ready);
endinterface

// ----- rtl/core/sts_core.sv -----
// Scanner state register and the single-pass per-byte token logic.
`include "source_token_scanner_macros.svh"
module sts_core (
   input  logic             clock,
   input  logic             reset,
   sts_req_if.sink          req,
   input  logic             room,
   output sts_pkg::push_type push
);
   import sts_pkg::*;

   scan_state_type state_ff;
   scan_state_type state_in;
   logic           xfer;

   assign req.ready = room;
   assign xfer      = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= reset_state();
      end else if (xfer) begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      step_type       c1;
      step_type       c2;
      step_type       c3;
      scan_state_type s2;
      token_type      eof_tok;
      logic [1:0]     n;

      c1 = cont_step(state_ff, req.in_byte);
      c2 = '0;
      s2 = c1.st;
      if (!c1.consumed) begin
         c2 = start_step(c1.st, req.in_byte);
         s2 = c2.st;
      end
      s2.pos = sat_pos(state_ff.pos);

      // Close whatever is left open at end of input.
      c3 = '0;
      c3.st = s2;
      if (s2.mode == MODE_STRING) begin
         c3 = close_tok(c3, K_ERROR, E_OPEN_STR);
      end else if (s2.mode != MODE_IDLE && s2.mode != MODE_LINECOM
                   && s2.mode != MODE_BLOCKCOM) begin
         c3 = cont_step(s2, 8'h00);
      end

      eof_tok       = '0;
      eof_tok.kind  = K_EOF;
      eof_tok.err   = E_NONE;
      eof_tok.start = 24'(s2.pos);
      eof_tok.len   = '0;
      eof_tok.line  = 24'(c3.st.line);
      eof_tok.last  = 1'b1;

      push = '0;
      n    = 2'd0;
      if (c1.emit) begin
         push.tok[n] = c1.tok;
         n = n + 2'd1;
      end
      if (c2.emit) begin
         push.tok[n] = c2.tok;
         n = n + 2'd1;
      end
      if (req.end_of_input) begin
         if (c3.emit) begin
            push.tok[n] = c3.tok;
            n = n + 2'd1;
         end
         push.tok[n] = eof_tok;
         n = n + 2'd1;
         state_in = reset_state();
      end else begin
         state_in = s2;
      end
      push.count = xfer ? n : 2'd0;
   end

   `STS_ASSERT(a_eof_restarts, clock, reset, (xfer && req.end_of_input) |=> (state_ff.pos == '0 && state_ff.line == line_type'(1)))
   `STS_ASSERT(a_three_only_at_end, clock, reset, (push.count == 2'd3) |-> req.end_of_input)
   `STS_ASSERT_NEVER(a_depth_limit, clock, reset, state_ff.depth > 4'(NEST_LIMIT))

endmodule

// ----- rtl/core/sts_queue.sv -----
// Four-entry token queue between the scanner and the token channel.
`include "source_token_scanner_macros.svh"
module sts_queue (
   input  logic              clock,
   input  logic              reset,
   input  sts_pkg::push_type push,
   output logic              room,
   sts_rsp_if.source         rsp
);
   import sts_pkg::*;

   token_type  entry_ff [4];
   logic [1:0] wr_ptr_ff;
   logic [1:0] wr_ptr_in;
   logic [1:0] rd_ptr_ff;
   logic [1:0] rd_ptr_in;
   logic [2:0] count_ff;
   logic [2:0] count_in;
   logic       pop;

   assign pop  = rsp.valid && rsp.ready;
   assign room = count_ff <= 3'd1;

   assign wr_ptr_in = wr_ptr_ff + push.count;
   assign rd_ptr_in = rd_ptr_ff + {1'b0, pop};
   assign count_in  = count_ff + {1'b0, push.count} - {2'b00, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (2'(i) < push.count) begin
            entry_ff[wr_ptr_ff + 2'(i)] <= push.tok[i];
         end
      end
   end

   assign rsp.valid        = count_ff != 3'd0;
   assign rsp.token_kind   = entry_ff[rd_ptr_ff].kind;
   assign rsp.error_code   = entry_ff[rd_ptr_ff].err;
   assign rsp.start_offset = entry_ff[rd_ptr_ff].start;
   assign rsp.token_length = entry_ff[rd_ptr_ff].len;
   assign rsp.line_number  = entry_ff[rd_ptr_ff].line;
   assign rsp.last         = entry_ff[rd_ptr_ff].last;

   `STS_ASSERT_NEVER(a_overfill, clock, reset, count_ff > 3'd4)
   `STS_ASSERT_NEVER(a_push_no_room, clock, reset, (push.count != 2'd0) && !room)
   `STS_ASSERT(a_count_track, clock, reset, (push.count != 2'd0 && !pop) |=> (count_ff == $past(count_ff) + {1'b0, $past(push.count)}))

endmodule

// ----- rtl/core/source_token_scanner.sv -----
// Top level of the streaming source token scanner.
//
// Takes one source byte per transfer on req_chan and delivers tokens on rsp_chan
// (kind, error code, start offset, length, line, last). A byte is accepted in
// every cycle while the token queue holds at most one token; the byte is scanned
// in the cycle of its transfer by one pass of logic off the scanner state
// register, and the tokens it closes (none to three) are written into a
// four-entry queue whose head drives rsp_chan. Sustained rate: one byte per
// clock whenever each byte yields at most one token and rsp_chan is ready;
// a byte that closes two or three tokens (an operator ending a token, or the
// final byte) holds further transfers until the queue drains back to one entry,
// one token per clock while rsp_chan is ready. The final byte (end_of_input)
// closes any open token, adds the end-of-file token with last set, and returns
// the scanner to its reset state for a new stream. No clearing pass follows reset.
module source_token_scanner (
   input  logic      clock,
   input  logic      reset,
   sts_req_if.sink   req_chan,
   sts_rsp_if.source rsp_chan
);
   import sts_pkg::*;

   // Tokens from the scan logic and the queue's space flag.
   push_type push;
   logic     room;

   // Scan one byte per transfer and advance the state.
   sts_core u_core (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .room  (room),
      .push  (push)
   );

   // Hold finished tokens until rsp_chan takes them.
   sts_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .room  (room),
      .rsp   (rsp_chan)
   );

endmodule
